### hdl/partial_volume_voxel_resampler_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef PARTIAL_VOLUME_VOXEL_RESAMPLER_MACROS_SVH
`define PARTIAL_VOLUME_VOXEL_RESAMPLER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define PVVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define PVVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pvvr_pkg.sv
// Types and constants shared by the resampler modules.
package pvvr_pkg;

    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned WEIGHT_W   = 32;
    localparam int unsigned LABEL_W    = 8;
    localparam int unsigned TABLE_W    = 40;
    localparam int unsigned SUM_W      = 56;
    localparam int unsigned PROD_W     = 49;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified sample as it sits in the queue between front and back.
    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic                       valid;
        logic [WEIGHT_W-1:0]        weight;
        logic                       last;
        logic [WEIGHT_W-1:0]        volume;
        logic                       label_hit;
    } pvvr_item_t;

    // Request to the serial divider.
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [WEIGHT_W-1:0] divisor;
    } pvvr_div_req_t;

    // Status coming back from the serial divider.
    typedef struct packed {
        logic               done;
        logic [SUM_W-1:0]   quotient;
    } pvvr_div_rsp_t;

endpackage

### hdl/partial_volume_voxel_resampler.sv
// Partial-volume voxel resampler: grey weighted average or label vote per target voxel.
//
// Input words arrive on the s_ stream, one source sample per word; s_tlast marks the
// last sample of a target voxel, and that word also carries the target volume. Each
// voxel yields exactly one result word on the m_ stream when its last sample is done.
// cfg_wr_en/cfg_wr_data write the data class (0 grey average, 1 label vote); write it
// only while the block is idle.
// Each sample passes through a read state, which reads the label table memory
// (registered read port) and forms the weight*value product, then an update state,
// which writes the table and updates the running sum and the running best label. A
// two-word queue between the input stage and the back end lets the input side keep
// accepting words meanwhile. Closing a voxel runs a finish state and then the output
// state; in grey mode a divide state can lie between them, in which a restoring
// divider produces one quotient bit per cycle for sum/volume. Reset (aresetn low,
// synchronous) empties the queue and clears all voxel state and the data class; no
// clearing pass is needed, since the label table uses one valid bit per entry. If
// m_tready stays low, the result word holds and the back end stops at its next voxel
// end, after which the queue fills and s_tready drops.
module partial_volume_voxel_resampler
    import pvvr_pkg::*;
#(
    parameter int unsigned LABEL_COUNT = 256,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,     // data_class
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,         // sample_value, overlap_weight, target_volume
    input  logic         s_tuser,         // sample_valid
    input  logic         s_tlast,         // last_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,         // voxel_value
    output logic         m_tuser          // voxel_undefined
);

    pvvr_item_t head;
    logic       q_empty;
    logic       pop;

    // Input stage: masks weights, classifies the label and queues the sample.
    pvvr_front #(
        .LABEL_COUNT (LABEL_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .pop      (pop),
        .q_empty  (q_empty),
        .head     (head)
    );

    // Back end: accumulation, voxel close-out and the output register.
    pvvr_back #(
        .LABEL_COUNT (LABEL_COUNT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### hdl/pvvr_front.sv
// Input stage: masks and classifies samples and queues them for the back end.
module pvvr_front
    import pvvr_pkg::*;
#(
    parameter int unsigned LABEL_COUNT = 256,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [79:0]               s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      pop,
    output logic                      q_empty,
    output pvvr_item_t                head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
        WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    pvvr_item_t         q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    pvvr_item_t         item_in;
    logic               push;

    always_comb begin
        item_in.value     = s_tdata[15:0];
        item_in.valid     = s_tuser;
        item_in.weight    = s_tdata[47:16] & WEIGHT_MASK;
        item_in.last      = s_tlast;
        item_in.volume    = s_tdata[79:48] & WEIGHT_MASK;
        // A sample feeds the label table only if it exists and its label is in range.
        item_in.label_hit = s_tuser && ({1'b0, s_tdata[7:0]} < 9'(LABEL_COUNT));
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_empty  = (count_reg == '0);
    assign head     = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### hdl/pvvr_div.sv
// Restoring divider: one quotient bit per cycle, unsigned operands.
module pvvr_div
    import pvvr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  pvvr_div_req_t req,
    output pvvr_div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(SUM_W);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WEIGHT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [WEIGHT_W-1:0]  dvs_reg, dvs_next;
    logic                 done_reg, done_next;
    logic [WEIGHT_W:0]    shifted;
    logic [WEIGHT_W:0]    diff;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[WEIGHT_W]) begin
                rem_next = diff[WEIGHT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[WEIGHT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/pvvr_back.sv
// Back end: label table read-modify-write, running sums, final result and output register.
`include "partial_volume_voxel_resampler_macros.svh"
module pvvr_back
    import pvvr_pkg::*;
#(
    parameter int unsigned LABEL_COUNT = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          q_empty,
    input  pvvr_item_t    head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tuser
);

    localparam int unsigned IDX_W = $clog2(LABEL_COUNT);
    localparam logic [TABLE_W-1:0] TABLE_MAX = '1;

    typedef enum logic [4:0] {
        ST_READ   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_FIN    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       class_reg;
    logic [LABEL_COUNT-1:0]     lvld_reg, lvld_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       missing_reg, missing_next;
    logic [TABLE_W-1:0]         bestw_reg, bestw_next;
    logic [LABEL_W-1:0]         bestl_reg, bestl_next;
    logic                       mvalid_reg, mvalid_next;

    pvvr_item_t                 item_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [TABLE_W-1:0]         rdata_reg;
    logic                       hit_reg;
    logic signed [VALUE_W-1:0]  resv_reg, resv_next;
    logic                       resu_reg, resu_next;
    logic [15:0]                mdata_reg;
    logic                       muser_reg;

    logic [TABLE_W-1:0]         table_mem [LABEL_COUNT];

    logic [IDX_W-1:0]           head_idx, item_idx;
    logic [TABLE_W-1:0]         tbl_old, tbl_new;
    logic [TABLE_W:0]           tbl_sum;
    logic signed [SUM_W:0]      acc_sum;
    logic                       out_free;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_mag;
    logic [SUM_W-1:0]           quo;
    pvvr_div_req_t              div_req;
    pvvr_div_rsp_t              div_rsp;

    assign head_idx = head.value[IDX_W-1:0];
    assign item_idx = item_reg.value[IDX_W-1:0];
    assign pop      = (state_reg == ST_READ) && !q_empty;
    assign out_free = !mvalid_reg || m_tready;

    assign tbl_old  = hit_reg ? rdata_reg : '0;
    assign tbl_sum  = {1'b0, tbl_old} + (TABLE_W + 1)'(item_reg.weight);
    assign tbl_new  = tbl_sum[TABLE_W] ? TABLE_MAX : tbl_sum[TABLE_W-1:0];
    assign acc_sum  = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_mag  = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo      = div_rsp.quotient;

    assign div_req.start    = (state_reg == ST_FIN) && !class_reg && !missing_reg
                              && (item_reg.volume != '0);
    assign div_req.dividend = sum_mag;
    assign div_req.divisor  = item_reg.volume;

    pvvr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        lvld_next    = lvld_reg;
        sum_next     = sum_reg;
        missing_next = missing_reg;
        bestw_next   = bestw_reg;
        bestl_next   = bestl_reg;
        mvalid_next  = mvalid_reg;
        resv_next    = resv_reg;
        resu_next    = resu_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_READ: begin
                if (!q_empty) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!item_reg.valid) begin
                    missing_next = 1'b1;
                end else begin
                    if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
                        sum_next = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                  : {1'b0, {(SUM_W-1){1'b1}}};
                    end else begin
                        sum_next = acc_sum[SUM_W-1:0];
                    end
                end
                if (item_reg.label_hit) begin
                    lvld_next[item_idx] = 1'b1;
                    if ((tbl_new > bestw_reg) || ((tbl_new == bestw_reg)
                        && (item_reg.value[LABEL_W-1:0] < bestl_reg))) begin
                        bestw_next = tbl_new;
                        bestl_next = item_reg.value[LABEL_W-1:0];
                    end
                end
                state_next = item_reg.last ? ST_FIN : ST_READ;
            end
            ST_FIN: begin
                if (class_reg) begin
                    resu_next  = (bestw_reg == '0);
                    resv_next  = (bestw_reg == '0) ? '0 : VALUE_W'(bestl_reg);
                    state_next = ST_OUT;
                end else if (div_req.start) begin
                    state_next = ST_DIV;
                end else begin
                    resu_next  = 1'b1;
                    resv_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    resu_next = 1'b0;
                    if (sum_neg) begin
                        resv_next = (quo >= SUM_W'(32768)) ? 16'sh8000
                                                           : $signed(16'd0 - quo[15:0]);
                    end else begin
                        resv_next = (quo > SUM_W'(32767)) ? 16'sh7FFF
                                                          : $signed(quo[15:0]);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mvalid_next  = 1'b1;
                    lvld_next    = '0;
                    sum_next     = '0;
                    missing_next = 1'b0;
                    bestw_next   = '0;
                    bestl_next   = '0;
                    state_next   = ST_READ;
                end
            end
            default: begin
                state_next = ST_READ;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_READ;
            class_reg   <= 1'b0;
            lvld_reg    <= '0;
            sum_reg     <= '0;
            missing_reg <= 1'b0;
            bestw_reg   <= '0;
            bestl_reg   <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                class_reg <= cfg_wr_data;
            end
            lvld_reg    <= lvld_next;
            sum_reg     <= sum_next;
            missing_reg <= missing_next;
            bestw_reg   <= bestw_next;
            bestl_reg   <= bestl_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        resv_reg <= resv_next;
        resu_reg <= resu_next;
        if (pop) begin
            item_reg  <= head;
            prod_reg  <= $signed({1'b0, head.weight}) * head.value;
            rdata_reg <= table_mem[head_idx];
            hit_reg   <= lvld_reg[head_idx];
        end
        if ((state_reg == ST_OUT) && out_free) begin
            mdata_reg <= resv_reg;
            muser_reg <= resu_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_UPDATE) && item_reg.label_hit) begin
            table_mem[item_idx] <= tbl_new;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    `PVVR_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_reg == ST_DIV, "divider finished outside the divide state")
    `PVVR_ASSERT_NEXT(a_mid_sample_returns, (state_reg == ST_UPDATE) && !item_reg.last, state_reg == ST_READ, "non-final sample did not return to read")
    `PVVR_ASSERT_NOW(a_result_from_out, $rose(mvalid_reg), $past(state_reg) == ST_OUT, "result word loaded outside the output state")
    `PVVR_ASSERT_NEXT(a_table_entry_marked, (state_reg == ST_UPDATE) && item_reg.label_hit, lvld_reg[$past(item_idx)], "written table entry not marked valid")

endmodule
